>>> rtl/ctp_pkg.sv
package ctp_pkg;

    // Transition kinds
    localparam logic [1:0] KIND_ENTRY     = 2'd0;
    localparam logic [1:0] KIND_EXIT      = 2'd1;
    localparam logic [1:0] KIND_EXCEPTION = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_CALL      = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    // Entry and exit kinds of a call record
    localparam logic       ENTRY_NORMAL    = 1'b0;
    localparam logic       ENTRY_SYNTHETIC = 1'b1;
    localparam logic [1:0] EXIT_NORMAL     = 2'd0;
    localparam logic [1:0] EXIT_SYNTHETIC  = 2'd1;
    localparam logic [1:0] EXIT_EXCEPTION  = 2'd2;

    // Register indexes
    localparam logic REG_TOP_LEVEL  = 1'b0;
    localparam logic REG_SKIP_FIRST = 1'b1;

    localparam int          DEPTH_W   = 31;
    localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;

    // Result queue holds up to two records
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  kind;
        logic [31:0] procedure;
        logic [63:0] timestamp;
        logic [31:0] info;
        logic [31:0] position;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_kind;
        logic [1:0]  exit_kind;
        logic [31:0] call_procedure;
        logic [63:0] entry_time;
        logic [63:0] exit_time;
        logic [31:0] caller_ip;
        logic [31:0] result_value;
        logic [31:0] call_handle;
        logic [31:0] child_calls;
        logic        last;
    } out_t;

    typedef struct packed {
        logic top_level;
        logic skip_first;
    } cfg_t;

endpackage

>>> rtl/ctp_engine.sv
module ctp_engine #(
    parameter int PROC_W = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  ctp_pkg::cfg_t  cfg,
    input  ctp_pkg::in_t   item,
    input  logic           take,
    output logic [1:0]     res_cnt,
    output ctp_pkg::out_t  rec0,
    output ctp_pkg::out_t  rec1
);

    logic [ctp_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic                        halted_reg, halted_next;
    logic                        skip_reg, skip_next;
    logic [PROC_W-1:0]           open_proc_reg, open_proc_next;
    logic [63:0]                 open_time_reg, open_time_next;
    logic [PROC_W-1:0]           open_caller_reg, open_caller_next;
    logic [31:0]                 open_pos_reg, open_pos_next;
    logic [31:0]                 open_kids_reg, open_kids_next;
    logic                        open_synth_reg, open_synth_next;

    logic [PROC_W-1:0]           proc_m;
    logic [PROC_W-1:0]           caller_m;
    logic [ctp_pkg::DEPTH_W-1:0] d_eff;
    logic                        h_eff;
    logic                        sk_eff;
    logic [PROC_W-1:0]           op_eff;
    logic [63:0]                 ot_eff;
    logic [PROC_W-1:0]           oc_eff;
    logic [31:0]                 opos_eff;
    logic [31:0]                 ok_eff;
    logic                        os_eff;

    assign proc_m   = item.procedure[PROC_W-1:0];
    assign caller_m = item.info[PROC_W-1:0];

    always_comb begin
        // A start clears the tracking state, reloading skip from cfg, before the transition is handled
        d_eff    = item.start_req ? '0 : depth_reg;
        h_eff    = item.start_req ? 1'b0 : halted_reg;
        sk_eff   = item.start_req ? cfg.skip_first : skip_reg;
        op_eff   = item.start_req ? '0 : open_proc_reg;
        ot_eff   = item.start_req ? '0 : open_time_reg;
        oc_eff   = item.start_req ? '0 : open_caller_reg;
        opos_eff = item.start_req ? '0 : open_pos_reg;
        ok_eff   = item.start_req ? '0 : open_kids_reg;
        os_eff   = item.start_req ? 1'b0 : open_synth_reg;

        depth_next       = d_eff;
        halted_next      = h_eff;
        skip_next        = sk_eff;
        open_proc_next   = op_eff;
        open_time_next   = ot_eff;
        open_caller_next = oc_eff;
        open_pos_next    = opos_eff;
        open_kids_next   = ok_eff;
        open_synth_next  = os_eff;

        res_cnt = 2'd0;
        rec0    = '0;
        rec1    = '0;

        if (!h_eff) begin
            if (sk_eff) begin
                skip_next = 1'b0;
            end else begin
                case (item.kind)
                    ctp_pkg::KIND_UNKNOWN: begin
                        rec0.status = ctp_pkg::ST_INVALID;
                        rec0.last   = 1'b1;
                        res_cnt     = 2'd1;
                        halted_next = 1'b1;
                    end
                    ctp_pkg::KIND_ENTRY: begin
                        if (d_eff == '0) begin
                            open_proc_next   = proc_m;
                            open_time_next   = item.timestamp;
                            open_caller_next = caller_m;
                            open_pos_next    = item.position;
                            open_kids_next   = '0;
                            open_synth_next  = 1'b0;
                        end else if (ok_eff != '1) begin
                            open_kids_next = ok_eff + 32'd1;
                        end
                        if (d_eff != ctp_pkg::DEPTH_MAX) begin
                            depth_next = d_eff + 31'd1;
                        end
                    end
                    default: begin
                        if (d_eff == '0) begin
                            if (!cfg.top_level) begin
                                rec0.status = ctp_pkg::ST_UNDERFLOW;
                                rec0.last   = 1'b1;
                                res_cnt     = 2'd1;
                                halted_next = 1'b1;
                            end
                        end else begin
                            depth_next = d_eff - 31'd1;
                            if (d_eff == 31'd1) begin
                                // Call record closed by this exit
                                rec1.status         = ctp_pkg::ST_CALL;
                                rec1.exit_kind      = (item.kind == ctp_pkg::KIND_EXIT) ?
                                                      ctp_pkg::EXIT_NORMAL :
                                                      ctp_pkg::EXIT_EXCEPTION;
                                rec1.exit_time      = item.timestamp;
                                rec1.result_value   = item.info;
                                rec1.last           = 1'b1;
                                if (op_eff != proc_m) begin
                                    // Close the open call, then report a synthetic entry
                                    rec0.status         = ctp_pkg::ST_CALL;
                                    rec0.entry_kind     = os_eff ? ctp_pkg::ENTRY_SYNTHETIC :
                                                                   ctp_pkg::ENTRY_NORMAL;
                                    rec0.exit_kind      = ctp_pkg::EXIT_SYNTHETIC;
                                    rec0.call_procedure = 32'(op_eff);
                                    rec0.entry_time     = ot_eff;
                                    rec0.exit_time      = item.timestamp;
                                    rec0.caller_ip      = 32'(oc_eff);
                                    rec0.result_value   = '0;
                                    rec0.call_handle    = opos_eff;
                                    rec0.child_calls    = ok_eff;
                                    rec0.last           = 1'b0;
                                    rec1.entry_kind     = ctp_pkg::ENTRY_SYNTHETIC;
                                    rec1.call_procedure = 32'(proc_m);
                                    rec1.entry_time     = item.timestamp;
                                    rec1.caller_ip      = '0;
                                    rec1.call_handle    = '0;
                                    rec1.child_calls    = '0;
                                    res_cnt             = 2'd2;
                                end else begin
                                    rec1.entry_kind     = os_eff ? ctp_pkg::ENTRY_SYNTHETIC :
                                                                   ctp_pkg::ENTRY_NORMAL;
                                    rec1.call_procedure = 32'(op_eff);
                                    rec1.entry_time     = ot_eff;
                                    rec1.caller_ip      = 32'(oc_eff);
                                    rec1.call_handle    = opos_eff;
                                    rec1.child_calls    = ok_eff;
                                    rec0                = rec1;
                                    res_cnt             = 2'd1;
                                end
                                open_proc_next   = '0;
                                open_time_next   = '0;
                                open_caller_next = '0;
                                open_pos_next    = '0;
                                open_kids_next   = '0;
                                open_synth_next  = 1'b0;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg       <= '0;
            halted_reg      <= 1'b0;
            skip_reg        <= 1'b0;
            open_proc_reg   <= '0;
            open_time_reg   <= '0;
            open_caller_reg <= '0;
            open_pos_reg    <= '0;
            open_kids_reg   <= '0;
            open_synth_reg  <= 1'b0;
        end else if (take) begin
            depth_reg       <= depth_next;
            halted_reg      <= halted_next;
            skip_reg        <= skip_next;
            open_proc_reg   <= open_proc_next;
            open_time_reg   <= open_time_next;
            open_caller_reg <= open_caller_next;
            open_pos_reg    <= open_pos_next;
            open_kids_reg   <= open_kids_next;
            open_synth_reg  <= open_synth_next;
        end
    end

endmodule

>>> rtl/ctp_result_queue.sv
module ctp_result_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [1:0]     push_cnt,
    input  ctp_pkg::out_t  rec0,
    input  ctp_pkg::out_t  rec1,
    input  logic           pop_ready,
    output logic           head_valid,
    output ctp_pkg::out_t  head,
    output logic [1:0]     free_slots
);

    logic [1:0]    cnt_reg, cnt_next;
    ctp_pkg::out_t slot0_reg, slot0_next;
    ctp_pkg::out_t slot1_reg, slot1_next;
    logic          pop;
    logic [1:0]    cnt_after;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot0_reg;
    assign pop        = head_valid && pop_ready;
    assign cnt_after  = cnt_reg - {1'b0, pop};
    assign free_slots = ctp_pkg::QUEUE_DEPTH - cnt_after;

    always_comb begin
        // Advance the head on pop, then append new records behind what remains
        if (cnt_after != 2'd0) begin
            slot0_next = pop ? slot1_reg : slot0_reg;
        end else begin
            slot0_next = rec0;
        end
        if (cnt_after == 2'd2) begin
            slot1_next = slot1_reg;
        end else if (cnt_after == 2'd1) begin
            slot1_next = rec0;
        end else begin
            slot1_next = rec1;
        end
        cnt_next = cnt_after + push_cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> rtl/call_trace_pairing_core.sv
// Channel   Ports                          Payload
// -------   ----------------------------   ----------------------------------
// input     s_valid, s_ready, s_item       ctp_pkg::in_t, one trace transition
// result    m_valid, m_ready, m_result     ctp_pkg::out_t, one call or status
// config    psel/penable/pwrite/paddr/...  register 0 top-level mode, 4 skip
//
// One transition per cycle while the queue has room. A record reaches the result port
// through the input register and the queue: the input register loads at acceptance, the queue when the engine takes it.
// A transition leaves the input register only when the queue has room for all its records,
// so a transition that yields two records waits until the queue has been drained.
// Synchronous active-low reset clears depth, open call and queue.
// A stalled result port fills the two-entry queue, then the input stalls.
module call_trace_pairing_core #(
    parameter int ADDR_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,

    input  logic           s_valid,
    output logic           s_ready,
    input  ctp_pkg::in_t   s_item,

    output logic           m_valid,
    input  logic           m_ready,
    output ctp_pkg::out_t  m_result,

    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int PROC_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    ctp_pkg::cfg_t cfg_reg;
    logic          in_vld_reg;
    ctp_pkg::in_t  in_item_reg;
    logic          take;
    logic [1:0]    res_cnt;
    logic [1:0]    free_slots;
    ctp_pkg::out_t rec0;
    ctp_pkg::out_t rec1;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ctp_pkg::REG_SKIP_FIRST) ? {31'd0, cfg_reg.skip_first} :
                                                            {31'd0, cfg_reg.top_level};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_level  <= 1'b1;
            cfg_reg.skip_first <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ctp_pkg::REG_SKIP_FIRST) begin
                cfg_reg.skip_first <= pwdata[0];
            end else begin
                cfg_reg.top_level <= pwdata[0];
            end
        end
    end

    // Consume the held transaction only when the queue has room for all its records
    assign take    = in_vld_reg && (res_cnt <= free_slots);
    assign s_ready = !in_vld_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    ctp_engine #(
        .PROC_W (PROC_W)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .take    (take),
        .res_cnt (res_cnt),
        .rec0    (rec0),
        .rec1    (rec1)
    );

    ctp_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (take ? res_cnt : 2'd0),
        .rec0       (rec0),
        .rec1       (rec1),
        .pop_ready  (m_ready),
        .head_valid (m_valid),
        .head       (m_result),
        .free_slots (free_slots)
    );

endmodule
